// ===== sv/plip_pkg.sv =====
// plip_pkg: shared types and constants of the piecewise-linear inner product
// used by the divider, the channel interfaces and the top level
package plip_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int X_W     = 16;
   localparam int LVL_W   = 16;
   localparam int SCALE_W = 24;
   localparam int OUT_W   = 48;
   localparam int DIV_W   = 38;   // dividend and quotient width of the divider
   localparam int DVS_W   = 16;   // divisor width of the divider
   localparam int V_W     = 22;   // interpolated level, six extra fraction bits
   localparam int W_W     = 47;   // weighted product sum of one piece
   localparam int S_W     = 64;   // running integral
   localparam int ACC_W   = 68;   // scaling accumulator
   localparam int U_W     = 44;   // integral after first scale

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SK_ISSUE,
      ST_SK_RD1,
      ST_SK_CMP,
      ST_LOOP,
      ST_IP_M1,
      ST_IP_M2,
      ST_IP_DIV,
      ST_IP_WAIT,
      ST_W_MUL,
      ST_ACC_LO,
      ST_ACC_HI,
      ST_ADV,
      ST_FIN,
      ST_T_FOLD,
      ST_T_SUM,
      ST_U_LO,
      ST_U_HI,
      ST_U_RND,
      ST_R_LO,
      ST_R_HI,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== sv/plip_req_if.sv =====
// plip_req_if: point input channel, valid/ready with the point fields
// depends on plip_pkg for field widths
interface plip_req_if import plip_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [X_W-1:0]     x_pos;
   logic [LVL_W-1:0]   level;
   logic [SCALE_W-1:0] scale;
   logic               last;

   modport source (output valid, func, x_pos, level, scale, last, input ready);
   modport sink   (input valid, func, x_pos, level, scale, last, output ready);
endinterface

// ===== sv/plip_rsp_if.sv =====
// plip_rsp_if: result channel, valid/ready with the result fields
// depends on plip_pkg for field widths
interface plip_rsp_if import plip_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] integral;
   logic             overlap;
   logic             truncated;

   modport source (output valid, integral, overlap, truncated, input ready);
   modport sink   (input valid, integral, overlap, truncated, output ready);
endinterface

// ===== sv/piecewise_linear_inner_product.sv =====
// piecewise_linear_inner_product: top level, point loading, merge walk and scaling
// depends on plip_pkg, plip_req_if, plip_rsp_if, plip_ram and plip_div
//
// Loads two piecewise-linear spectra as (x_pos, level) points, one beat per cycle,
// into one point memory (first list at 0, second at MAX_POINTS). Closing the second
// list (func 1, last 1) starts the walk: both lists are stepped in merge order, with
// points whose x does not increase skipped, and the exact integral of the product of
// the two lines over each common piece is summed. The sum is scaled by both scales
// and one result beat is sent; counts and the truncation flag then clear. Outside
// ST_IDLE (walk, scaling and result hand-off), req_chan.ready is low. The walk reads
// the points through one read port with a registered read and steps past each skipped
// point; each common piece takes four interpolations through the shared bit-serial
// divider. The final rounding folds the divide by three into shifts and small constant
// multiplies before both scales are applied. A finished result waits in the output
// register while new points load.
module piecewise_linear_inner_product import plip_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input logic        clock,
   input logic        reset,
   plip_req_if.sink   req_chan,
   plip_rsp_if.source rsp_chan
);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int DEPTH = 2 * MAX_POINTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = X_W + LVL_W;

   // block state
   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic [SCALE_W-1:0] sc0_ff, sc0_in, sc1_ff, sc1_in;
   logic               first_done_ff, first_done_in;
   logic               ovf_ff, ovf_in;

   // seek of the next valid segment in one list
   logic               sel_ff, sel_in;
   logic [CW-1:0]      kk_ff, kk_in;
   logic [CW-1:0]      bstart_ff, bstart_in;
   logic               pend_b_ff, pend_b_in;
   logic [X_W-1:0]     p0x_ff, p0x_in;
   logic [LVL_W-1:0]   p0y_ff, p0y_in;

   // current segments
   logic [CW-1:0]      ia_ff, ia_in, jb_ff, jb_in;
   logic [X_W-1:0]     a0x_ff, a0x_in, a1x_ff, a1x_in, b0x_ff, b0x_in, b1x_ff, b1x_in;
   logic [LVL_W-1:0]   a0y_ff, a0y_in, a1y_ff, a1y_in, b0y_ff, b0y_in, b1y_ff, b1y_in;

   // piece arithmetic
   logic [X_W-1:0]     pos_ff, pos_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [S_W-1:0]     s_ff, s_in;
   logic               ov_ff, ov_in;
   logic [1:0]         q_ff, q_in, wq_ff, wq_in;
   logic [31:0]        prod_ff, prod_in, num_ff, num_in;
   logic [V_W-1:0]     v_ff [4];
   logic [V_W-1:0]     v_in [4];
   logic [W_W-1:0]     w_ff, w_in;

   // scaling
   logic [35:0]        t_ff, t_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [U_W-1:0]     u_ff, u_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   integral_ff, integral_in;
   logic               overlap_ff, overlap_in;
   logic               truncated_ff, truncated_in;

   // memory and divider
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [PW-1:0]      ram_wdata, ram_rdata;
   div_req_type        div_req;
   logic               div_done;
   logic [DIV_W-1:0]   div_quo;

   // combinational helpers
   logic               accept;
   logic [CW-1:0]      base0, n_sel;
   logic [X_W-1:0]     rd_x;
   logic [LVL_W-1:0]   rd_y;
   logic               commit, commit_full;
   logic [CW-1:0]      commit_idx;
   logic [X_W-1:0]     lo1, lo_c, hi_c, dx;
   logic [X_W-1:0]     sg_x0, sg_x1, xq;
   logic [LVL_W-1:0]   sg_y0, sg_y1;
   logic [V_W-1:0]     mf, mg;
   logic [2*V_W-1:0]   mfg;
   logic [2*V_W:0]     term;
   logic [ACC_W-1:0]   r_full;
   logic [S_W-1:0]     s_rnd;
   logic [36:0]        tn;

   plip_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   plip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   function automatic logic [AW-1:0] pt_addr(input logic sel, input logic [CW-1:0] k);
      logic [AW:0] a;
      a = sel ? (AW+1)'(MAX_POINTS) + (AW+1)'(k) : (AW+1)'(k);
      return a[AW-1:0];
   endfunction

   assign accept = req_chan.valid && req_chan.ready;
   assign rd_x   = ram_rdata[PW-1:LVL_W];
   assign rd_y   = ram_rdata[LVL_W-1:0];
   assign n_sel  = sel_ff ? cnt1_ff : cnt0_ff;

   // common piece of the two current segments
   assign lo1  = (a0x_ff > b0x_ff) ? a0x_ff : b0x_ff;
   assign lo_c = (pos_ff > lo1) ? pos_ff : lo1;
   assign hi_c = (a1x_ff < b1x_ff) ? a1x_ff : b1x_ff;
   assign dx   = hi_ff - lo_ff;

   // interpolation operands: q[1] picks the list, q[0] the piece end
   assign sg_x0 = q_ff[1] ? b0x_ff : a0x_ff;
   assign sg_x1 = q_ff[1] ? b1x_ff : a1x_ff;
   assign sg_y0 = q_ff[1] ? b0y_ff : a0y_ff;
   assign sg_y1 = q_ff[1] ? b1y_ff : a1y_ff;
   assign xq    = q_ff[0] ? hi_ff : lo_ff;

   // weight terms: 2*fa*ga, fa*gb, fb*ga, 2*fb*gb
   assign mf   = wq_ff[1] ? v_ff[1] : v_ff[0];
   assign mg   = wq_ff[0] ? v_ff[3] : v_ff[2];
   assign mfg  = mf * mg;
   assign term = (wq_ff == 2'd0 || wq_ff == 2'd3) ? {mfg, 1'b0} : {1'b0, mfg};

   assign r_full = (acc_ff + ACC_W'(16'h8000)) >> 16;

   // sum rounded and taken down by 2^27, still to be divided by three
   assign s_rnd = s_ff + S_W'(64'd3 << 26);
   assign tn    = s_rnd[S_W-1:27];

   always_comb begin
      state_in      = state_ff;
      cnt0_in       = cnt0_ff;
      cnt1_in       = cnt1_ff;
      sc0_in        = sc0_ff;
      sc1_in        = sc1_ff;
      first_done_in = first_done_ff;
      ovf_in        = ovf_ff;
      sel_in        = sel_ff;
      kk_in         = kk_ff;
      bstart_in     = bstart_ff;
      pend_b_in     = pend_b_ff;
      p0x_in        = p0x_ff;
      p0y_in        = p0y_ff;
      ia_in         = ia_ff;
      jb_in         = jb_ff;
      a0x_in = a0x_ff; a1x_in = a1x_ff; b0x_in = b0x_ff; b1x_in = b1x_ff;
      a0y_in = a0y_ff; a1y_in = a1y_ff; b0y_in = b0y_ff; b1y_in = b1y_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      s_in          = s_ff;
      ov_in         = ov_ff;
      q_in          = q_ff;
      wq_in         = wq_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      t_in          = t_ff;
      acc_in        = acc_ff;
      u_in          = u_ff;
      rsp_valid_in  = rsp_valid_ff;
      integral_in   = integral_ff;
      overlap_in    = overlap_ff;
      truncated_in  = truncated_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = {req_chan.x_pos, req_chan.level};
      ram_raddr     = pt_addr(sel_ff, kk_ff);
      div_req       = '0;
      base0         = first_done_ff ? '0 : cnt0_ff;
      commit        = 1'b0;
      commit_full   = 1'b0;
      commit_idx    = kk_ff;

      // result beat leaves the output register
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_chan.func) begin
                  // a point after a closed first list starts a new list
                  if (base0 < CW'(MAX_POINTS)) begin
                     ram_we    = 1'b1;
                     ram_waddr = pt_addr(1'b0, base0);
                     cnt0_in   = base0 + 1'b1;
                  end else begin
                     cnt0_in = base0;
                     ovf_in  = 1'b1;
                  end
                  first_done_in = req_chan.last;
                  if (req_chan.last) begin
                     sc0_in = req_chan.scale;
                  end
               end else begin
                  if (cnt1_ff < CW'(MAX_POINTS)) begin
                     ram_we    = 1'b1;
                     ram_waddr = pt_addr(1'b1, cnt1_ff);
                     cnt1_in   = cnt1_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_chan.last) begin
                     // second list closed: start the walk with a seek on each list
                     sc1_in    = req_chan.scale;
                     sel_in    = 1'b0;
                     kk_in     = '0;
                     bstart_in = '0;
                     pend_b_in = 1'b1;
                     pos_in    = '0;
                     s_in      = '0;
                     ov_in     = 1'b0;
                     state_in  = ST_SK_ISSUE;
                  end
               end
            end
         end

         ST_SK_ISSUE: begin
            if ({1'b0, kk_ff} + 1'b1 >= {1'b0, n_sel}) begin
               commit = 1'b1;
            end else begin
               ram_raddr = pt_addr(sel_ff, kk_ff);
               state_in  = ST_SK_RD1;
            end
         end

         ST_SK_RD1: begin
            p0x_in    = rd_x;
            p0y_in    = rd_y;
            ram_raddr = pt_addr(sel_ff, CW'(kk_ff + 1'b1));
            state_in  = ST_SK_CMP;
         end

         ST_SK_CMP: begin
            if (p0x_ff >= rd_x) begin
               // segment does not rise in x: step past its start point
               kk_in  = kk_ff + 1'b1;
               p0x_in = rd_x;
               p0y_in = rd_y;
               if ({1'b0, kk_ff} + 2'd2 < {1'b0, n_sel}) begin
                  ram_raddr = pt_addr(sel_ff, CW'(kk_ff + 2'd2));
               end else begin
                  commit     = 1'b1;
                  commit_idx = kk_ff + 1'b1;
               end
            end else begin
               commit      = 1'b1;
               commit_full = 1'b1;
            end
         end

         ST_LOOP: begin
            if (({1'b0, ia_ff} + 1'b1 < {1'b0, cnt0_ff}) &&
                ({1'b0, jb_ff} + 1'b1 < {1'b0, cnt1_ff})) begin
               lo_in = lo_c;
               hi_in = hi_c;
               if (lo_c < hi_c) begin
                  q_in     = '0;
                  state_in = ST_IP_M1;
               end else begin
                  state_in = ST_ADV;
               end
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_IP_M1: begin
            prod_in  = 32'(sg_y0 * (sg_x1 - xq));
            state_in = ST_IP_M2;
         end

         ST_IP_M2: begin
            num_in   = prod_ff + 32'(sg_y1 * (xq - sg_x0));
            state_in = ST_IP_DIV;
         end

         ST_IP_DIV: begin
            // rounded half up: (num * 64 + d / 2) / d
            div_req.start    = 1'b1;
            div_req.dividend = {num_ff, 6'b0} + DIV_W'((sg_x1 - sg_x0) >> 1);
            div_req.divisor  = sg_x1 - sg_x0;
            state_in         = ST_IP_WAIT;
         end

         ST_IP_WAIT: begin
            if (div_done) begin
               v_in[q_ff] = div_quo[V_W-1:0];
               if (q_ff == 2'd3) begin
                  wq_in    = '0;
                  w_in     = '0;
                  state_in = ST_W_MUL;
               end else begin
                  q_in     = q_ff + 1'b1;
                  state_in = ST_IP_M1;
               end
            end
         end

         ST_W_MUL: begin
            w_in  = w_ff + W_W'(term);
            wq_in = wq_ff + 1'b1;
            if (wq_ff == 2'd3) begin
               state_in = ST_ACC_LO;
            end
         end

         ST_ACC_LO: begin
            s_in     = s_ff + S_W'(dx * w_ff[23:0]);
            state_in = ST_ACC_HI;
         end

         ST_ACC_HI: begin
            s_in     = s_ff + (S_W'(dx * w_ff[W_W-1:24]) << 24);
            ov_in    = 1'b1;
            pos_in   = hi_ff;
            state_in = ST_ADV;
         end

         ST_ADV: begin
            // step every list whose segment ends at the piece end
            if (a1x_ff <= b1x_ff) begin
               sel_in    = 1'b0;
               kk_in     = ia_ff + 1'b1;
               pend_b_in = (b1x_ff <= a1x_ff);
               bstart_in = jb_ff + 1'b1;
            end else begin
               sel_in    = 1'b1;
               kk_in     = jb_ff + 1'b1;
               pend_b_in = 1'b0;
            end
            state_in = ST_SK_ISSUE;
         end

         ST_FIN: begin
            if (ov_ff) begin
               // T = round(S / (6 * 2^26)) = floor(tn / 3), with tn = (S + 3 * 2^26) / 2^27
               // 2^18 = 3 * 87381 + 1, so tn / 3 = 87381 * high + (high + low) / 3
               t_in     = 36'(tn[36:18] * 17'd87381);
               acc_in   = ACC_W'(tn[36:18]) + ACC_W'(tn[17:0]);
               state_in = ST_T_FOLD;
            end else begin
               state_in = ST_OUT;
            end
         end

         ST_T_FOLD: begin
            // 2^10 = 3 * 341 + 1: fold the 20 bit rest once more
            t_in     = t_ff + 36'(acc_ff[19:10] * 9'd341);
            acc_in   = ACC_W'(acc_ff[19:10]) + ACC_W'(acc_ff[9:0]);
            state_in = ST_T_SUM;
         end

         ST_T_SUM: begin
            // rest below 2^11: k / 3 = (k * 683) >> 11
            t_in     = t_ff + 36'((acc_ff[10:0] * 10'd683) >> 11);
            state_in = ST_U_LO;
         end

         ST_U_LO: begin
            acc_in   = ACC_W'(t_ff[17:0] * sc0_ff);
            state_in = ST_U_HI;
         end

         ST_U_HI: begin
            acc_in   = acc_ff + (ACC_W'(t_ff[35:18] * sc0_ff) << 18);
            state_in = ST_U_RND;
         end

         ST_U_RND: begin
            u_in     = r_full[U_W-1:0];
            state_in = ST_R_LO;
         end

         ST_R_LO: begin
            acc_in   = ACC_W'(u_ff[21:0] * sc1_ff);
            state_in = ST_R_HI;
         end

         ST_R_HI: begin
            acc_in   = acc_ff + (ACC_W'(u_ff[U_W-1:22] * sc1_ff) << 22);
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               overlap_in   = ov_ff;
               truncated_in = ovf_ff;
               if (!ov_ff) begin
                  integral_in = '0;
               end else if (r_full > ACC_W'({OUT_W{1'b1}})) begin
                  integral_in = {OUT_W{1'b1}};
               end else begin
                  integral_in = r_full[OUT_W-1:0];
               end
               cnt0_in       = '0;
               cnt1_in       = '0;
               first_done_in = 1'b0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // seek finished: load the segment and go on with the other list or the walk
      if (commit) begin
         if (!sel_ff) begin
            ia_in = commit_idx;
            if (commit_full) begin
               a0x_in = p0x_ff; a0y_in = p0y_ff;
               a1x_in = rd_x;   a1y_in = rd_y;
            end
         end else begin
            jb_in = commit_idx;
            if (commit_full) begin
               b0x_in = p0x_ff; b0y_in = p0y_ff;
               b1x_in = rd_x;   b1y_in = rd_y;
            end
         end
         if (!sel_ff && pend_b_ff) begin
            sel_in    = 1'b1;
            kk_in     = bstart_ff;
            pend_b_in = 1'b0;
            state_in  = ST_SK_ISSUE;
         end else begin
            state_in = ST_LOOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt0_ff       <= '0;
         cnt1_ff       <= '0;
         sc0_ff        <= '0;
         sc1_ff        <= '0;
         first_done_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt0_ff       <= cnt0_in;
         cnt1_ff       <= cnt1_in;
         sc0_ff        <= sc0_in;
         sc1_ff        <= sc1_in;
         first_done_ff <= first_done_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sel_ff    <= sel_in;
      kk_ff     <= kk_in;
      bstart_ff <= bstart_in;
      pend_b_ff <= pend_b_in;
      p0x_ff    <= p0x_in;
      p0y_ff    <= p0y_in;
      ia_ff     <= ia_in;
      jb_ff     <= jb_in;
      a0x_ff <= a0x_in; a1x_ff <= a1x_in; b0x_ff <= b0x_in; b1x_ff <= b1x_in;
      a0y_ff <= a0y_in; a1y_ff <= a1y_in; b0y_ff <= b0y_in; b1y_ff <= b1y_in;
      pos_ff    <= pos_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      s_ff      <= s_in;
      ov_ff     <= ov_in;
      q_ff      <= q_in;
      wq_ff     <= wq_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      t_ff      <= t_in;
      acc_ff    <= acc_in;
      u_ff      <= u_in;
      integral_ff  <= integral_in;
      overlap_ff   <= overlap_in;
      truncated_ff <= truncated_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.integral  = integral_ff;
   assign rsp_chan.overlap   = overlap_ff;
   assign rsp_chan.truncated = truncated_ff;
endmodule

// ===== sv/plip_ram.sv =====
// plip_ram: generic single write, single read memory with registered read
// no dependencies
module plip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/plip_div.sv =====
// plip_div: restoring divider, one quotient bit per cycle
// depends on plip_pkg for widths and the request struct
module plip_div import plip_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
